/* rtl/core/lpcf_pkg.sv */
// ---------------------------------------------------------------------------
// lpcf_pkg
// Shared widths, character codes, register indices, state encoding and the
// overstrike lookup for the line printer character formatter.
// ---------------------------------------------------------------------------
`default_nettype none

package lpcf_pkg;

  localparam int CHAR_W = 8;
  localparam int REP_W  = 8;
  localparam int COL_W  = 8;
  localparam int LINE_W = 9;
  localparam int MODE_W = 4;
  localparam int IDX_W  = 2;
  localparam int DATA_W = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [LINE_W-1:0] line_t;

  // character codes
  localparam char_t CH_BEL        = 8'h07;
  localparam char_t CH_BS         = 8'h08;
  localparam char_t CH_TAB        = 8'h09;
  localparam char_t CH_LF         = 8'h0A;
  localparam char_t CH_VT         = 8'h0B;
  localparam char_t CH_FF         = 8'h0C;
  localparam char_t CH_CR         = 8'h0D;
  localparam char_t CH_SPACE      = 8'h20;
  localparam char_t CH_DASH       = 8'h2D;
  localparam char_t CH_UNDERSCORE = 8'h5F;
  localparam char_t CH_LOWER_A    = 8'h61;
  localparam char_t CH_LOWER_Z    = 8'h7A;
  localparam char_t CASE_OFFSET   = 8'h20;
  localparam char_t MARK_BIT      = 8'h80;
  localparam char_t LOW7_MASK     = 8'h7F;

  // column limits
  localparam col_t COL_MAX       = 8'd255;
  localparam col_t TAB_LAST_STOP = 8'd248;
  localparam col_t INDENT_COL    = 8'd8;

  // mode bit positions
  localparam int M_RAW    = 0;
  localparam int M_UPPER  = 1;
  localparam int M_WASTE  = 2;
  localparam int M_INDENT = 3;

  // configuration register indices
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEPTH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RST  = 4'd0;
  localparam col_t              WIDTH_RST = 8'd131;
  localparam col_t              DEPTH_RST = 8'd60;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECODE   = 11'b000_0000_0010,
    S_PR_CR    = 11'b000_0000_0100,
    S_PR_WIDTH = 11'b000_0000_1000,
    S_PR_PAD   = 11'b000_0001_0000,
    S_PR_CHAR  = 11'b000_0010_0000,
    S_OVR      = 11'b000_0100_0000,
    S_NL_CR    = 11'b000_1000_0000,
    S_NL_LINE  = 11'b001_0000_0000,
    S_VT       = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    char_t            out_char;
    logic [REP_W-1:0] repeat_res;
  } res_t;

  typedef struct packed {
    logic  hit;
    char_t base;
  } ovr_t;

  // overstrike rendering: special character -> base character, struck with '-'
  function automatic ovr_t ovr_map(input char_t c);
    ovr_t r;
    r.hit  = 1'b1;
    r.base = c;
    case (c)
      8'h7B: r.base = 8'h28;  // {  ->  (
      8'h7D: r.base = 8'h29;  // }  ->  )
      8'h7C: r.base = 8'h21;  // |  ->  !
      8'h7E: r.base = 8'h5E;  // ~  ->  ^
      8'h60: r.base = 8'h27;  // `  ->  '
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lpcf_in_if.sv */
// ---------------------------------------------------------------------------
// lpcf_in_if
// Input byte channel: valid/ready handshake carrying one byte per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface lpcf_in_if;
  logic                 valid;
  logic                 ready;
  logic [lpcf_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

/* rtl/core/lpcf_out_if.sv */
// ---------------------------------------------------------------------------
// lpcf_out_if
// Printer symbol channel: symbol, repeat count and end-of-byte flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface lpcf_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpcf_pkg::CHAR_W-1:0] out_char;
  logic [lpcf_pkg::REP_W-1:0]  repeat_res;
  logic                        last;

  modport source (output valid, output out_char, output repeat_res, output last,
                  input ready);
  modport sink   (input valid, input out_char, input repeat_res, input last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/lpcf_cfg_if.sv */
// ---------------------------------------------------------------------------
// lpcf_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface lpcf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lpcf_pkg::IDX_W-1:0]  index;
  logic [lpcf_pkg::DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/line_printer_char_formatter.sv */
// ---------------------------------------------------------------------------
// line_printer_char_formatter
// Turns bytes written to a line printer into printer symbols.
//
// One byte is taken at a time; the input is not ready until every symbol it
// causes has been handed to the output register. A small sequencer walks
// the byte through decode, print (carriage return, pad run, character),
// newline and vertical tab steps, using one shared 9-bit subtract/compare
// unit for the carriage return, width, pad and page depth tests. A step
// that emits a symbol waits while the output side holds off. Symbols pass
// through a one-entry holding stage so the final one of a byte can be
// flagged with last; the output register lets the next byte start while
// that final symbol still waits to be taken. A byte that causes no symbol
// produces no transfer at all. Configuration writes are accepted at any
// time but should be made only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module line_printer_char_formatter (
  input  logic       clk,
  input  logic       rst,
  lpcf_in_if.sink    in_ch,
  lpcf_out_if.source out_ch,
  lpcf_cfg_if.sink   cfg
);

  // configuration
  logic [lpcf_pkg::MODE_W-1:0] mode_bits;
  lpcf_pkg::col_t              page_width;
  lpcf_pkg::col_t              page_depth;

  // formatter state
  lpcf_pkg::state_t state, state_next;
  lpcf_pkg::col_t   logical_column, logical_column_next;
  lpcf_pkg::col_t   printed_column, printed_column_next;
  lpcf_pkg::line_t  line_count, line_count_next;
  lpcf_pkg::char_t  cur_char, cur_char_next;   // character being worked on
  lpcf_pkg::char_t  nl_char, nl_char_next;     // LF/FF symbol for the newline
  logic             ovr_pend, ovr_pend_next;   // '-' still to strike over
  logic             vt_pend, vt_pend_next;     // inside a vertical tab run

  // holding stage and output register
  lpcf_pkg::res_t hold;
  logic           hold_valid;
  lpcf_pkg::res_t out_res;
  logic           out_valid;
  logic           out_last;

  logic           in_fire;
  logic           out_free;
  logic           emit_req;
  lpcf_pkg::res_t emit_res;
  logic           flush_last;
  logic           stall;
  logic           push;

  // shared subtract/compare unit
  lpcf_pkg::line_t      opa, opb;
  logic [lpcf_pkg::LINE_W:0] diff;
  logic                 a_lt_b;
  logic                 a_eq_b;

  lpcf_pkg::line_t  line_inc;
  lpcf_pkg::col_t   col_inc;
  lpcf_pkg::col_t   col_dec;
  lpcf_pkg::col_t   line_start_col;
  lpcf_pkg::ovr_t   ovr;
  lpcf_pkg::char_t  dec_char;
  lpcf_pkg::char_t  dec_low7;
  lpcf_pkg::char_t  nl_sym;

  assign in_ch.ready = (state == lpcf_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;

  assign out_ch.valid      = out_valid;
  assign out_ch.out_char   = out_res.out_char;
  assign out_ch.repeat_res = out_res.repeat_res;
  assign out_ch.last       = out_last;

  assign out_free = !out_valid || out_ch.ready;

  // --- configuration registers --------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits  <= lpcf_pkg::MODE_RST;
      page_width <= lpcf_pkg::WIDTH_RST;
      page_depth <= lpcf_pkg::DEPTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lpcf_pkg::REG_MODE:  mode_bits  <= cfg.data[lpcf_pkg::MODE_W-1:0];
        lpcf_pkg::REG_WIDTH: page_width <= cfg.data;
        lpcf_pkg::REG_DEPTH: page_depth <= cfg.data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --- operand select for the shared unit ---------------------------------
  assign line_inc = line_count + 9'd1;

  always_comb begin
    opa = {1'b0, logical_column};
    opb = {1'b0, printed_column};
    case (state)
      lpcf_pkg::S_PR_WIDTH: opb = {1'b0, page_width};
      lpcf_pkg::S_NL_LINE: begin
        // forced form feed when the new line count passes the page depth
        opa = {1'b0, page_depth};
        opb = line_inc;
      end
      default: ;
    endcase
  end

  assign diff   = {1'b0, opa} - {1'b0, opb};
  assign a_lt_b = diff[lpcf_pkg::LINE_W];
  assign a_eq_b = (diff[lpcf_pkg::LINE_W-1:0] == '0);

  // small column helpers
  assign col_inc = (logical_column == lpcf_pkg::COL_MAX) ? logical_column
                                                          : logical_column + 8'd1;
  assign col_dec = (logical_column == '0) ? logical_column : logical_column - 8'd1;
  assign line_start_col = mode_bits[lpcf_pkg::M_INDENT] ? lpcf_pkg::INDENT_COL : '0;

  // decode: case folding and overstrike lookup
  assign ovr = lpcf_pkg::ovr_map(cur_char);

  always_comb begin
    dec_char = cur_char;
    if (mode_bits[lpcf_pkg::M_UPPER] &&
        (cur_char inside {[lpcf_pkg::CH_LOWER_A:lpcf_pkg::CH_LOWER_Z]})) begin
      dec_char = cur_char - lpcf_pkg::CASE_OFFSET;
    end
  end

  assign dec_low7 = dec_char & lpcf_pkg::LOW7_MASK;

  // only an exact FF code clears the line count; a marked FF does not
  assign nl_sym = ((page_depth != '0) && a_lt_b) ? lpcf_pkg::CH_FF : nl_char;

  // --- sequencer ----------------------------------------------------------
  always_comb begin
    state_next          = state;
    logical_column_next = logical_column;
    printed_column_next = printed_column;
    line_count_next     = line_count;
    cur_char_next       = cur_char;
    nl_char_next        = nl_char;
    ovr_pend_next       = ovr_pend;
    vt_pend_next        = vt_pend;
    emit_req            = 1'b0;
    emit_res.out_char   = cur_char;
    emit_res.repeat_res = 8'd1;
    flush_last          = 1'b0;

    case (state)
      lpcf_pkg::S_IDLE: begin
        if (in_fire) begin
          // underscore gains the mark bit before anything else
          cur_char_next = (in_ch.char_in == lpcf_pkg::CH_UNDERSCORE) ?
                          (in_ch.char_in | lpcf_pkg::MARK_BIT) : in_ch.char_in;
          ovr_pend_next = 1'b0;
          vt_pend_next  = 1'b0;
          state_next    = lpcf_pkg::S_DECODE;
        end
      end

      lpcf_pkg::S_DECODE: begin
        if (mode_bits[lpcf_pkg::M_RAW]) begin
          emit_req   = 1'b1;
          state_next = lpcf_pkg::S_FINISH;
        end else if (mode_bits[lpcf_pkg::M_UPPER] && ovr.hit) begin
          // print the base first, then strike '-' over it
          cur_char_next = ovr.base;
          ovr_pend_next = 1'b1;
          state_next    = lpcf_pkg::S_PR_CR;
        end else begin
          cur_char_next = dec_char;
          state_next    = lpcf_pkg::S_FINISH;
          case (dec_low7)
            lpcf_pkg::CH_TAB: begin
              logical_column_next = (logical_column >= lpcf_pkg::TAB_LAST_STOP) ?
                lpcf_pkg::COL_MAX : {logical_column[7:3] + 5'd1, 3'b000};
            end
            lpcf_pkg::CH_FF, lpcf_pkg::CH_LF: begin
              nl_char_next = dec_char;
              state_next   = lpcf_pkg::S_NL_CR;
            end
            lpcf_pkg::CH_CR:    logical_column_next = line_start_col;
            lpcf_pkg::CH_BS:    logical_column_next = col_dec;
            lpcf_pkg::CH_BEL: begin
              emit_req          = 1'b1;
              emit_res.out_char = dec_char;
            end
            lpcf_pkg::CH_SPACE: logical_column_next = col_inc;
            lpcf_pkg::CH_VT: begin
              vt_pend_next = 1'b1;
              nl_char_next = lpcf_pkg::CH_LF;
              state_next   = (printed_column != '0) ? lpcf_pkg::S_NL_CR : lpcf_pkg::S_VT;
            end
            default: begin
              // remaining control codes are dropped
              if (dec_low7 >= lpcf_pkg::CH_SPACE) state_next = lpcf_pkg::S_PR_CR;
            end
          endcase
        end
      end

      lpcf_pkg::S_PR_CR: begin
        // head right of target column: return the carriage
        if (a_lt_b) begin
          emit_req            = 1'b1;
          emit_res.out_char   = lpcf_pkg::CH_CR;
          printed_column_next = '0;
        end
        state_next = lpcf_pkg::S_PR_WIDTH;
      end

      lpcf_pkg::S_PR_WIDTH: begin
        if (a_lt_b) begin
          state_next = lpcf_pkg::S_PR_PAD;
        end else begin
          // clipped past the page width
          logical_column_next = col_inc;
          state_next = ovr_pend ? lpcf_pkg::S_OVR : lpcf_pkg::S_FINISH;
        end
      end

      lpcf_pkg::S_PR_PAD: begin
        if (!a_lt_b && !a_eq_b) begin
          emit_req            = 1'b1;
          emit_res.out_char   = lpcf_pkg::CH_SPACE;
          emit_res.repeat_res = diff[lpcf_pkg::REP_W-1:0];
          printed_column_next = logical_column;
        end
        state_next = lpcf_pkg::S_PR_CHAR;
      end

      lpcf_pkg::S_PR_CHAR: begin
        emit_req            = 1'b1;
        printed_column_next = printed_column + 8'd1;
        logical_column_next = col_inc;
        state_next = ovr_pend ? lpcf_pkg::S_OVR : lpcf_pkg::S_FINISH;
      end

      lpcf_pkg::S_OVR: begin
        logical_column_next = col_dec;
        cur_char_next       = lpcf_pkg::CH_DASH;
        ovr_pend_next       = 1'b0;
        state_next          = lpcf_pkg::S_PR_CR;
      end

      lpcf_pkg::S_NL_CR: begin
        if ((printed_column != '0) || (line_count != '0) ||
            mode_bits[lpcf_pkg::M_WASTE]) begin
          if (printed_column != '0) begin
            emit_req          = 1'b1;
            emit_res.out_char = lpcf_pkg::CH_CR;
          end
          printed_column_next = '0;
          state_next          = lpcf_pkg::S_NL_LINE;
        end else begin
          // blank line at top of page is swallowed
          logical_column_next = line_start_col;
          state_next = vt_pend ? lpcf_pkg::S_VT : lpcf_pkg::S_FINISH;
        end
      end

      lpcf_pkg::S_NL_LINE: begin
        emit_req            = 1'b1;
        emit_res.out_char   = nl_sym;
        line_count_next     = (nl_sym == lpcf_pkg::CH_FF) ? '0 : line_inc;
        printed_column_next = '0;
        logical_column_next = line_start_col;
        state_next = vt_pend ? lpcf_pkg::S_VT : lpcf_pkg::S_FINISH;
      end

      lpcf_pkg::S_VT: begin
        // keep feeding lines until a multiple of eight
        if (line_count[2:0] != 3'd0) begin
          nl_char_next = lpcf_pkg::CH_LF;
          state_next   = lpcf_pkg::S_NL_CR;
        end else begin
          state_next = lpcf_pkg::S_FINISH;
        end
      end

      lpcf_pkg::S_FINISH: begin
        if (!hold_valid) begin
          state_next = lpcf_pkg::S_IDLE;
        end else if (out_free) begin
          flush_last = 1'b1;
          state_next = lpcf_pkg::S_IDLE;
        end
      end

      default: state_next = lpcf_pkg::S_IDLE;
    endcase
  end

  // a new symbol needs the held one moved on first
  assign stall = emit_req && hold_valid && !out_free;
  assign push  = (emit_req && !stall && hold_valid) || flush_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lpcf_pkg::S_IDLE;
      logical_column <= '0;
      printed_column <= '0;
      line_count     <= '0;
      ovr_pend       <= 1'b0;
      vt_pend        <= 1'b0;
    end else if (!stall) begin
      state          <= state_next;
      logical_column <= logical_column_next;
      printed_column <= printed_column_next;
      line_count     <= line_count_next;
      ovr_pend       <= ovr_pend_next;
      vt_pend        <= vt_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      cur_char <= cur_char_next;
      nl_char  <= nl_char_next;
    end
  end

  // holding stage and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_req && !stall) begin
        hold_valid <= 1'b1;
      end else if (flush_last) begin
        hold_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && !stall) begin
      hold <= emit_res;
    end
    if (push) begin
      out_res  <= hold;
      out_last <= flush_last;
    end
  end

  // --- assertions ---------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("formatter state not one-hot");

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == lpcf_pkg::S_IDLE) |-> !hold_valid)
    else $error("symbol left in holding stage at idle");

  a_nonlast_has_follower: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> hold_valid)
    else $error("non-final symbol shown with nothing held behind it");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == lpcf_pkg::S_DECODE))
    else $error("accepted byte not decoded next cycle");

  a_idle_columns_stable: assert property (@(posedge clk) disable iff (rst)
    ((state == lpcf_pkg::S_IDLE) && !in_fire) |=>
      ($stable(logical_column) && $stable(printed_column) && $stable(line_count)))
    else $error("column or line state moved while idle");

endmodule

`default_nettype wire
